// ----- rtl/hslp_pkg.sv -----
// Package for the HTTP status line parser: phase, tag and verdict codes,
// the step result struct and small character helpers.
// No dependencies.
`default_nettype none

package hslp_pkg;

    typedef logic [2:0] phase_t;
    typedef logic [2:0] pos_t;
    typedef logic [1:0] tag_t;
    typedef logic [1:0] verdict_t;

    localparam phase_t PH_PREFIX   = 3'd0;
    localparam phase_t PH_MAJOR    = 3'd1;
    localparam phase_t PH_MINOR    = 3'd2;
    localparam phase_t PH_CODE     = 3'd3;
    localparam phase_t PH_REASON   = 3'd4;
    localparam phase_t PH_ACCEPTED = 3'd5;
    localparam phase_t PH_REJECTED = 3'd6;

    localparam tag_t TAG_NONE    = 2'd0;
    localparam tag_t TAG_VERSION = 2'd1;
    localparam tag_t TAG_CODE    = 2'd2;
    localparam tag_t TAG_REASON  = 2'd3;

    localparam verdict_t V_PENDING  = 2'd0;
    localparam verdict_t V_ACCEPTED = 2'd1;
    localparam verdict_t V_REJECTED = 2'd2;

    localparam pos_t PREFIX_LEN = 3'd5;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        phase_t   phase;
        pos_t     pos;
        tag_t     tag;
        verdict_t verdict;
    } step_t;

    function automatic logic [7:0] prefix_char(input pos_t pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            default: c = 8'h48;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            u = c - 8'd32;
        end
        return u;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hslp_step.sv -----
// Next-state logic of the status line parser for one byte.
// Depends on hslp_pkg.
`default_nettype none

module hslp_step
    import hslp_pkg::*;
(
    input  wire phase_t     phase,
    input  wire pos_t       pos,
    input  wire logic [7:0] in_byte,
    input  wire logic       last_byte,
    output step_t           step
);

    pos_t   cur_pos;
    phase_t next_phase;
    pos_t   next_pos;
    tag_t   tag;

    always_comb
    begin
        cur_pos    = (pos < PREFIX_LEN) ? pos : 3'd0;
        next_phase = phase;
        next_pos   = pos;
        tag        = TAG_NONE;
        case (phase)
            PH_PREFIX:
            begin
                if (to_upper(in_byte) == prefix_char(cur_pos))
                begin
                    if (cur_pos == PREFIX_LEN - 3'd1)
                    begin
                        next_phase = PH_MAJOR;
                        next_pos   = 3'd0;
                    end
                    else
                    begin
                        next_pos = cur_pos + 3'd1;
                    end
                end
                else
                begin
                    next_phase = PH_REJECTED;
                end
            end
            PH_MAJOR:
            begin
                if (is_digit(in_byte))
                begin
                    tag = TAG_VERSION;
                end
                else if (in_byte == CH_DOT)
                begin
                    tag        = TAG_VERSION;
                    next_phase = PH_MINOR;
                end
                else
                begin
                    next_phase = PH_REJECTED;
                end
            end
            PH_MINOR:
            begin
                if (is_digit(in_byte))
                begin
                    tag = TAG_VERSION;
                end
                else if (in_byte == CH_SPACE)
                begin
                    next_phase = PH_CODE;
                end
                else
                begin
                    next_phase = PH_REJECTED;
                end
            end
            PH_CODE:
            begin
                if (is_digit(in_byte))
                begin
                    tag = TAG_CODE;
                end
                else if (in_byte == CH_SPACE)
                begin
                    next_phase = PH_REASON;
                end
                else
                begin
                    next_phase = PH_REJECTED;
                end
            end
            PH_REASON:
            begin
                if (in_byte == CH_CR || in_byte == CH_LF)
                begin
                    next_phase = PH_ACCEPTED;
                end
                else
                begin
                    tag = TAG_REASON;
                end
            end
            PH_ACCEPTED:
            begin
                next_phase = PH_ACCEPTED;
            end
            default:
            begin
                next_phase = PH_REJECTED;
            end
        endcase

        step.tag = tag;
        if (next_phase == PH_REASON || next_phase == PH_ACCEPTED)
        begin
            step.verdict = V_ACCEPTED;
        end
        else if (next_phase == PH_REJECTED || last_byte)
        begin
            step.verdict = V_REJECTED;
        end
        else
        begin
            step.verdict = V_PENDING;
        end

        if (last_byte)
        begin
            step.phase = PH_PREFIX;
            step.pos   = 3'd0;
        end
        else
        begin
            step.phase = next_phase;
            step.pos   = next_pos;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/http_status_line_parser.sv -----
// Top level of the HTTP status line parser: input register, parser state,
// output register. Depends on hslp_pkg and hslp_step.
//
// Usage: the bytes of a status line enter on the s_axis channel, one byte
// per transfer, with s_axis_tlast high on the final byte of the line. Each
// byte leaves on the m_axis channel as one transfer: the byte in
// m_axis_tdata, its field tag and the verdict so far in m_axis_tuser.
// A byte is registered at the input, parsed against the stored phase and
// prefix count, and written to the output register once that register is
// empty or its transfer is taken. One byte per cycle is sustained while
// m_axis_tready stays high; the state update is the loop that sets that
// rate. The input accepts a new byte while a result waits, as long as the
// input register is empty or moves on in the same cycle.
// When the receiver holds m_axis_tready low, the output register keeps its
// transfer, the input register fills, and s_axis_tready then drops.
// Reset empties both registers and returns the parser to prefix matching.
// A transfer with s_axis_tlast high also returns it to prefix matching.
`default_nettype none

module http_status_line_parser
    import hslp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // in_byte [7:0]
    input  wire logic       s_axis_tlast,  // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // out_byte [7:0]
    output logic [3:0]      m_axis_tuser   // field_tag [1:0], verdict [3:2]
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    phase_t     phase_reg;
    pos_t       pos_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    tag_t       out_tag_reg;
    verdict_t   out_verdict_reg;
    logic       advance;
    step_t      step;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    hslp_step u_step (
        .phase     (phase_reg),
        .pos       (pos_reg),
        .in_byte   (in_byte_reg),
        .last_byte (in_last_reg),
        .step      (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_PREFIX;
            pos_reg       <= 3'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= step.phase;
                pos_reg       <= step.pos;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_byte_reg    <= in_byte_reg;
            out_tag_reg     <= step.tag;
            out_verdict_reg <= step.verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_verdict_reg, out_tag_reg};

endmodule

`default_nettype wire

// ----- rtl/hslp_checker.sv -----
// Port-level checks for the HTTP status line parser, bound to the top level.
// Depends on hslp_pkg.
`default_nettype none

module hslp_checker
    import hslp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [3:0] m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Output transfer changed while stalled.");

    a_reason_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == TAG_REASON |->
            m_axis_tuser[3:2] == V_ACCEPTED)
        else $error("Reason phrase byte without accepted verdict.");

    a_early_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == TAG_VERSION ||
                          m_axis_tuser[1:0] == TAG_CODE) |->
            m_axis_tuser[3:2] != V_ACCEPTED)
        else $error("Version or code byte marked accepted.");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[3:2] != 2'd3)
        else $error("Undefined verdict code.");

    a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled with an empty output.");

endmodule

bind http_status_line_parser hslp_checker u_hslp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
